### rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define PIA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// condition must never be seen outside reset
`define PIA_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`endif

### rtl/pia_pkg.sv
// ----------------------------------------------------------------------------
// pia_pkg
// types and constants of the two-port parallel interface adapter
// ----------------------------------------------------------------------------
package pia_pkg;

  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 32;

  typedef enum logic [2:0] {
    CMD_READ   = 3'd0,
    CMD_WRITE  = 3'd1,
    CMD_CA1    = 3'd2,
    CMD_CA2    = 3'd3,
    CMD_CB1    = 3'd4,
    CMD_CB2    = 3'd5,
    CMD_LOAD_A = 3'd6,
    CMD_LOAD_B = 3'd7
  } cmd_e;

  // control register bit positions
  localparam int unsigned CtrlIrqEn  = 0;
  localparam int unsigned CtrlL1Edge = 1;
  localparam int unsigned CtrlData   = 2;
  localparam int unsigned CtrlL2Ctrl = 3;
  localparam int unsigned CtrlL2Edge = 4;
  localparam int unsigned CtrlL2Out  = 5;

  // line-2 output mode, control bits 4..3
  localparam logic [1:0] ModeStrobe = 2'b10;
  localparam logic [1:0] ModeManual = 2'b11;

  typedef struct packed {
    logic       rd;
    logic       wr;
    logic       ctl_sel;
    logic       l1_evt;
    logic       l2_evt;
    logic       load;
    logic       level;
    logic [7:0] wdata;
    logic [7:0] pins;
  } port_cmd_t;

  typedef struct packed {
    logic [7:0] rd_data;
    logic       irq;
    logic       l2;
    logic [7:0] drive;
    logic       strobe;
  } port_res_t;

endpackage

### rtl/pia_port.sv
// ----------------------------------------------------------------------------
// pia_port
// one port: output, direction and control registers, two flags, two lines
// ----------------------------------------------------------------------------
module pia_port (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  pia_pkg::port_cmd_t  cmd_i,
  output pia_pkg::port_res_t  res_o
);
  import pia_pkg::*;

  logic [7:0] out_q, out_d;
  logic [7:0] dir_q, dir_d;
  logic [5:0] ctrl_q, ctrl_d;
  logic       f1_q, f1_d, f2_q, f2_d;
  logic       l1_q, l1_d, l2_q, l2_d;
  logic [7:0] rd_data;
  logic       strobe;

  always_comb begin
    out_d   = out_q;
    dir_d   = dir_q;
    ctrl_d  = ctrl_q;
    f1_d    = f1_q;
    f2_d    = f2_q;
    l1_d    = l1_q;
    l2_d    = l2_q;
    rd_data = 8'h00;
    strobe  = 1'b0;
    if (cmd_i.rd) begin
      if (cmd_i.ctl_sel) begin
        rd_data = {f1_q, f2_q, ctrl_q};
      end else if (!ctrl_q[CtrlData]) begin
        rd_data = dir_q;
      end else begin
        rd_data = (out_q & dir_q) | (cmd_i.pins & ~dir_q);
        f1_d    = 1'b0;
        f2_d    = 1'b0;
      end
    end
    if (cmd_i.wr) begin
      if (cmd_i.ctl_sel) begin
        ctrl_d = cmd_i.wdata[5:0];
        if (cmd_i.wdata[CtrlL2Out] && cmd_i.wdata[4:3] == ModeManual) begin
          l2_d = cmd_i.wdata[CtrlL2Ctrl];
        end
      end else if (!ctrl_q[CtrlData]) begin
        dir_d = cmd_i.wdata;
      end else begin
        out_d = cmd_i.wdata;
        if (ctrl_q[CtrlL2Out] && ctrl_q[4:3] == ModeStrobe) begin
          l2_d   = 1'b1;
          strobe = 1'b1;
        end
      end
    end
    if (cmd_i.l1_evt) begin
      l1_d = cmd_i.level;
      if (ctrl_q[CtrlL1Edge] ? (!l1_q && cmd_i.level) : (l1_q && !cmd_i.level)) begin
        f1_d = 1'b1;
      end
    end
    if (cmd_i.l2_evt && !ctrl_q[CtrlL2Out]) begin
      l2_d = cmd_i.level;
      if (ctrl_q[CtrlL2Edge] ? (!l2_q && cmd_i.level) : (l2_q && !cmd_i.level)) begin
        f2_d = 1'b1;
      end
    end
    if (cmd_i.load) begin
      out_d = cmd_i.wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q  <= '0;
      dir_q  <= '0;
      ctrl_q <= '0;
      f1_q   <= 1'b0;
      f2_q   <= 1'b0;
      l1_q   <= 1'b0;
      l2_q   <= 1'b0;
    end else if (advance_i) begin
      out_q  <= out_d;
      dir_q  <= dir_d;
      ctrl_q <= ctrl_d;
      f1_q   <= f1_d;
      f2_q   <= f2_d;
      l1_q   <= l1_d;
      l2_q   <= l2_d;
    end
  end

  // result reflects the state after this item
  always_comb begin
    res_o.rd_data = rd_data;
    res_o.irq     = (f1_d && ctrl_d[CtrlIrqEn]) ||
                    (f2_d && !ctrl_d[CtrlL2Out] && ctrl_d[CtrlL2Ctrl]);
    res_o.l2      = l2_d;
    res_o.drive   = out_d & dir_d;
    res_o.strobe  = strobe;
  end

`include "assert_macros.svh"

  `PIA_ASSERT(a_read_clears_flags,
    advance_i && cmd_i.rd && !cmd_i.ctl_sel && ctrl_q[CtrlData] |=> !f1_q && !f2_q)
  `PIA_ASSERT(a_strobe_leaves_high, res_o.strobe |-> res_o.l2)
  `PIA_ASSERT(a_output_line_ignores_event,
    advance_i && cmd_i.l2_evt && ctrl_q[CtrlL2Out] |=> $stable(l2_q))

endmodule

### rtl/parallel_interface_adapter.sv
// ----------------------------------------------------------------------------
// parallel_interface_adapter
// two-port parallel interface adapter with bus access, line events and loads
// ----------------------------------------------------------------------------
//
//   channel   dir  fields (tdata, lowest bit first)
//   s_axis    in   command[2:0] reg_sel[4:3] write_data[12:5] line_level[13]
//                  pins_a[21:14] pins_b[29:22], zero pad [31:30]
//   m_axis    out  read_data[7:0] irq_a[8] irq_b[9] ca2_level[10]
//                  cb2_level[11] port_a_drive[19:12] port_b_drive[27:20]
//                  ca2_strobe[28] cb2_strobe[29], zero pad [31:30]
//
// one item per clock sustained while the output is not stalled; an item passes
// through the input register, then the port logic into the result register
// the port state registers update in the cycle an item moves into the result
// register, so each item sees all earlier items
// a stalled output holds the result register and the input register; with the
// result register empty the input side is always ready
// reset clears all port registers, flags and line levels
//
module parallel_interface_adapter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [pia_pkg::InDataW-1:0]  s_axis_tdata,   // command, reg_sel, write_data,
                                                       // line_level, pins_a, pins_b
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [pia_pkg::OutDataW-1:0] m_axis_tdata    // read_data, irq_a, irq_b,
                                                       // ca2_level, cb2_level,
                                                       // port_a_drive, port_b_drive,
                                                       // ca2_strobe, cb2_strobe
);
  import pia_pkg::*;

  // input register
  logic        in_vld_q;
  logic [29:0] in_q;
  logic        advance;

  // result register
  logic        out_vld_q;
  logic [29:0] out_q, out_d;

  // fields of the held item
  cmd_e       cmd;
  logic [1:0] reg_sel;
  logic [7:0] wdata;
  logic       level;
  logic [7:0] pins_a, pins_b;

  port_cmd_t cmd_a, cmd_b;
  port_res_t res_a, res_b;

  // item moves on when the result register is free or being drained
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q <= s_axis_tdata[29:0];
    end
  end

  assign cmd     = cmd_e'(in_q[2:0]);
  assign reg_sel = in_q[4:3];
  assign wdata   = in_q[12:5];
  assign level   = in_q[13];
  assign pins_a  = in_q[21:14];
  assign pins_b  = in_q[29:22];

  // command decode, split per port; reg_sel[1] picks the port of a bus access
  always_comb begin
    cmd_a         = '0;
    cmd_b         = '0;
    cmd_a.ctl_sel = reg_sel[0];
    cmd_b.ctl_sel = reg_sel[0];
    cmd_a.level   = level;
    cmd_b.level   = level;
    cmd_a.wdata   = wdata;
    cmd_b.wdata   = wdata;
    cmd_a.pins    = pins_a;
    cmd_b.pins    = pins_b;
    unique case (cmd)
      CMD_READ: begin
        cmd_a.rd = !reg_sel[1];
        cmd_b.rd = reg_sel[1];
      end
      CMD_WRITE: begin
        cmd_a.wr = !reg_sel[1];
        cmd_b.wr = reg_sel[1];
      end
      CMD_CA1:    cmd_a.l1_evt = 1'b1;
      CMD_CA2:    cmd_a.l2_evt = 1'b1;
      CMD_CB1:    cmd_b.l1_evt = 1'b1;
      CMD_CB2:    cmd_b.l2_evt = 1'b1;
      CMD_LOAD_A: cmd_a.load   = 1'b1;
      CMD_LOAD_B: cmd_b.load   = 1'b1;
      default: ;
    endcase
  end

  pia_port u_port_a (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .advance_i(advance),
    .cmd_i    (cmd_a),
    .res_o    (res_a)
  );

  pia_port u_port_b (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .advance_i(advance),
    .cmd_i    (cmd_b),
    .res_o    (res_b)
  );

  // only the addressed port returns nonzero read data
  assign out_d = {res_b.strobe, res_a.strobe, res_b.drive, res_a.drive,
                  res_b.l2, res_a.l2, res_b.irq, res_a.irq,
                  res_a.rd_data | res_b.rd_data};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_q};

`include "assert_macros.svh"

  `PIA_ASSERT(a_ready_when_result_empty, !out_vld_q |-> s_axis_tready)
  `PIA_ASSERT(a_full_and_stalled_blocks, in_vld_q && out_vld_q && !m_axis_tready
    |-> !s_axis_tready)
  `PIA_ASSERT_NEVER(a_strobe_with_read_data,
    out_vld_q && (out_q[28] || out_q[29]) && out_q[7:0] != 8'h00)

endmodule

### verif/parallel_interface_adapter_checker.sv
// ----------------------------------------------------------------------------
// parallel_interface_adapter_checker
// watches both stream channels, predicts each result and compares it
// ----------------------------------------------------------------------------
// every item accepted on the input side runs through a copy of the port
// logic kept here; the expected result waits in order until the matching
// output item arrives and is then compared field by field
// ----------------------------------------------------------------------------

package pia_tb_pkg;
  import pia_pkg::*;

  // register select codes of a bus access
  localparam logic [1:0] SelDataA = 2'd0;
  localparam logic [1:0] SelCtrlA = 2'd1;
  localparam logic [1:0] SelDataB = 2'd2;
  localparam logic [1:0] SelCtrlB = 2'd3;

  // input item, declared so that the first field sits in the lowest bits
  typedef struct packed {
    logic [7:0] pins_b;
    logic [7:0] pins_a;
    logic       level;
    logic [7:0] wdata;
    logic [1:0] sel;
    cmd_e       cmd;
  } pia_item_t;

  // result item, same convention
  typedef struct packed {
    logic       cb2_strobe;
    logic       ca2_strobe;
    logic [7:0] port_b_drive;
    logic [7:0] port_a_drive;
    logic       cb2_level;
    logic       ca2_level;
    logic       irq_b;
    logic       irq_a;
    logic [7:0] read_data;
  } pia_view_t;
endpackage

module parallel_interface_adapter_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [31:0] s_axis_tdata_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [31:0] m_axis_tdata_i,
  output int          mismatches_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import pia_pkg::*;
  import pia_tb_pkg::*;

  // shadow of the port state
  logic [7:0] a_out, a_dir, b_out, b_dir;
  logic [5:0] a_ctrl, b_ctrl;
  logic [3:0] flags;     // A1, A2, B1, B2
  logic [3:0] line_lv;   // CA1, CA2, CB1, CB2

  pia_view_t awaited_views[$];
  int        results_seen;

  task automatic report(input string what);
    mismatches_o++;
    if (mismatches_o <= 40)
      $display("[%0t] result %0d: %s", $realtime, results_seen, what);
  endtask

  task automatic check_field(input string name, input logic [7:0] seen,
                             input logic [7:0] want);
    if (seen !== want)
      report($sformatf("%s is 0x%02h, expected 0x%02h", name, seen, want));
  endtask

  function automatic logic irq_of(logic [5:0] c, logic f1, logic f2);
    return (f1 && c[CtrlIrqEn]) || (f2 && !c[CtrlL2Out] && c[CtrlL2Ctrl]);
  endfunction

  // record a new line level, set the flag of that line on the chosen edge
  function automatic void note_line(int unsigned idx, logic rising, logic lvl);
    logic was;
    was = line_lv[idx];
    line_lv[idx] = lvl;
    if (rising ? (!was && lvl) : (was && !lvl))
      flags[idx] = 1'b1;
  endfunction

  // apply one item to the shadow state and return what the block reports
  function automatic pia_view_t next_port_view(pia_item_t it);
    pia_view_t v;
    v = '0;
    case (it.cmd)
      CMD_READ: begin
        case (it.sel)
          SelDataA: begin
            if (!a_ctrl[CtrlData]) begin
              v.read_data = a_dir;
            end else begin
              flags[1:0] = 2'b00;
              v.read_data = (a_out & a_dir) | (it.pins_a & ~a_dir);
            end
          end
          SelCtrlA: v.read_data = {flags[0], flags[1], a_ctrl};
          SelDataB: begin
            if (!b_ctrl[CtrlData]) begin
              v.read_data = b_dir;
            end else begin
              flags[3:2] = 2'b00;
              v.read_data = (b_out & b_dir) | (it.pins_b & ~b_dir);
            end
          end
          default: v.read_data = {flags[2], flags[3], b_ctrl};
        endcase
      end
      CMD_WRITE: begin
        case (it.sel)
          SelDataA: begin
            if (!a_ctrl[CtrlData]) begin
              a_dir = it.wdata;
            end else begin
              a_out = it.wdata;
              if (a_ctrl[CtrlL2Out] && a_ctrl[CtrlL2Edge:CtrlL2Ctrl] == ModeStrobe) begin
                line_lv[1] = 1'b1;
                v.ca2_strobe = 1'b1;
              end
            end
          end
          SelCtrlA: begin
            a_ctrl = it.wdata[5:0];
            if (a_ctrl[CtrlL2Out] && a_ctrl[CtrlL2Edge:CtrlL2Ctrl] == ModeManual)
              line_lv[1] = a_ctrl[CtrlL2Ctrl];
          end
          SelDataB: begin
            if (!b_ctrl[CtrlData]) begin
              b_dir = it.wdata;
            end else begin
              b_out = it.wdata;
              if (b_ctrl[CtrlL2Out] && b_ctrl[CtrlL2Edge:CtrlL2Ctrl] == ModeStrobe) begin
                line_lv[3] = 1'b1;
                v.cb2_strobe = 1'b1;
              end
            end
          end
          default: begin
            b_ctrl = it.wdata[5:0];
            if (b_ctrl[CtrlL2Out] && b_ctrl[CtrlL2Edge:CtrlL2Ctrl] == ModeManual)
              line_lv[3] = b_ctrl[CtrlL2Ctrl];
          end
        endcase
      end
      CMD_CA1: note_line(0, a_ctrl[CtrlL1Edge], it.level);
      CMD_CA2: if (!a_ctrl[CtrlL2Out]) note_line(1, a_ctrl[CtrlL2Edge], it.level);
      CMD_CB1: note_line(2, b_ctrl[CtrlL1Edge], it.level);
      CMD_CB2: if (!b_ctrl[CtrlL2Out]) note_line(3, b_ctrl[CtrlL2Edge], it.level);
      CMD_LOAD_A: a_out = it.wdata;
      default: b_out = it.wdata;
    endcase
    v.irq_a        = irq_of(a_ctrl, flags[0], flags[1]);
    v.irq_b        = irq_of(b_ctrl, flags[2], flags[3]);
    v.ca2_level    = line_lv[1];
    v.cb2_level    = line_lv[3];
    v.port_a_drive = a_out & a_dir;
    v.port_b_drive = b_out & b_dir;
    return v;
  endfunction

  always @(posedge clk_i) begin
    pia_view_t seen, want;
    if (!rst_ni) begin
      a_out = '0; a_dir = '0; a_ctrl = '0;
      b_out = '0; b_dir = '0; b_ctrl = '0;
      flags = '0; line_lv = '0;
      mismatches_o = 0;
      results_seen = 0;
      awaited_views.delete();
    end else begin
      // output side first, so a result can never match an item of the same edge
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        seen = pia_view_t'(m_axis_tdata_i[29:0]);
        if (awaited_views.size() == 0) begin
          report("result arrived with nothing outstanding");
        end else begin
          want = awaited_views.pop_front();
          check_field("read_data", seen.read_data, want.read_data);
          check_field("irq_a", 8'(seen.irq_a), 8'(want.irq_a));
          check_field("irq_b", 8'(seen.irq_b), 8'(want.irq_b));
          check_field("ca2_level", 8'(seen.ca2_level), 8'(want.ca2_level));
          check_field("cb2_level", 8'(seen.cb2_level), 8'(want.cb2_level));
          check_field("port_a_drive", seen.port_a_drive, want.port_a_drive);
          check_field("port_b_drive", seen.port_b_drive, want.port_b_drive);
          check_field("ca2_strobe", 8'(seen.ca2_strobe), 8'(want.ca2_strobe));
          check_field("cb2_strobe", 8'(seen.cb2_strobe), 8'(want.cb2_strobe));
        end
        results_seen++;
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        awaited_views.push_back(next_port_view(pia_item_t'(s_axis_tdata_i[29:0])));
    end
    pending_o = awaited_views.size();
  end

endmodule

### verif/parallel_interface_adapter_tb.sv
// ----------------------------------------------------------------------------
// parallel_interface_adapter_tb
// stimulus and verdict for the two-port parallel interface adapter
// ----------------------------------------------------------------------------
// a directed opening walks both ports through direction and data select,
// flag setting and clearing, manual and strobe line-2 output and ignored
// line events; a random part of mostly register and line traffic follows,
// sent in bursts while the output side stalls on its own pattern
// ----------------------------------------------------------------------------

module parallel_interface_adapter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pia_pkg::*;
  import pia_tb_pkg::*;

  localparam int unsigned RandomItems = 800;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;    // command, reg_sel, write_data, line_level,
                                     // pins_a, pins_b
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // read_data, irq_a, irq_b, ca2_level,
                                     // cb2_level, port_a_drive, port_b_drive,
                                     // ca2_strobe, cb2_strobe

  int mismatches;
  int pending;

  // sender pacing: items left in the present burst, and whether gaps are on
  int unsigned burst_left = 0;
  logic        gaps_on = 1'b1;
  int unsigned sent_by_cmd[8];

  // receiver pacing
  int unsigned rx_cycle = 0;

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  parallel_interface_adapter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  parallel_interface_adapter_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .mismatches_o    (mismatches),
    .pending_o       (pending)
  );

  // receiver stalls: three patterns, rotated in turn
  // always ready, random stalls about a quarter of the time, and ready on
  // three fifths of the cycles in a repeating pattern
  always @(negedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    case ((rx_cycle / 300) % 3)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
      default: m_axis_tready <= ((rx_cycle % 5) < 3);
    endcase
  end

  function automatic pia_item_t mk(cmd_e cmd, logic [1:0] sel, logic [7:0] wdata,
                                   logic level, logic [7:0] pins_a,
                                   logic [7:0] pins_b);
    pia_item_t it;
    it.cmd    = cmd;
    it.sel    = sel;
    it.wdata  = wdata;
    it.level  = level;
    it.pins_a = pins_a;
    it.pins_b = pins_b;
    return it;
  endfunction

  // random item: all fields random, command mix weighted toward register
  // writes and line events so that flags and line-2 modes get exercised
  function automatic pia_item_t random_item();
    pia_item_t   it;
    int unsigned pick;
    it.sel    = 2'($urandom_range(0, 3));
    it.wdata  = 8'($urandom_range(0, 255));
    it.level  = 1'($urandom_range(0, 1));
    it.pins_a = 8'($urandom_range(0, 255));
    it.pins_b = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 22)
      it.cmd = CMD_READ;
    else if (pick < 50)
      it.cmd = CMD_WRITE;
    else if (pick < 90)
      it.cmd = cmd_e'(3'($urandom_range(2, 5)));   // one of the four line events
    else
      it.cmd = ($urandom_range(0, 1) != 0) ? CMD_LOAD_A : CMD_LOAD_B;
    return it;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input pia_item_t it);
    if (burst_left == 0) begin
      if (gaps_on) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    s_axis_tdata  <= {2'b00, it};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_by_cmd[it.cmd]++;
    @(negedge clk_i);
  endtask

  // run limit, far above the slowest legal run
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    pia_item_t opening[$];

    // reset held low at the start, then released on a falling edge
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // port A
    opening.push_back(mk(CMD_READ,   SelCtrlA, 8'h00, 1'b0, 8'h00, 8'h00)); // reset control
    opening.push_back(mk(CMD_WRITE,  SelDataA, 8'hF0, 1'b0, 8'h00, 8'h00)); // direction write
    opening.push_back(mk(CMD_READ,   SelDataA, 8'h00, 1'b0, 8'hFF, 8'hFF)); // direction read
    opening.push_back(mk(CMD_WRITE,  SelCtrlA, 8'hC7, 1'b0, 8'h00, 8'h00)); // top bits dropped
    opening.push_back(mk(CMD_WRITE,  SelDataA, 8'hFF, 1'b0, 8'h00, 8'h00)); // data, no strobe
    opening.push_back(mk(CMD_CA1,    SelDataA, 8'h00, 1'b1, 8'h00, 8'h00)); // rising edge flag
    opening.push_back(mk(CMD_READ,   SelCtrlA, 8'h00, 1'b0, 8'h00, 8'h00)); // flag in bit 7
    opening.push_back(mk(CMD_READ,   SelDataA, 8'h00, 1'b0, 8'h55, 8'h00)); // merge, clear
    opening.push_back(mk(CMD_WRITE,  SelCtrlA, 8'h34, 1'b0, 8'h00, 8'h00)); // strobe mode
    opening.push_back(mk(CMD_WRITE,  SelDataA, 8'h00, 1'b0, 8'h00, 8'h00)); // strobe pulse
    opening.push_back(mk(CMD_CA2,    SelDataA, 8'h00, 1'b0, 8'h00, 8'h00)); // ignored, output
    opening.push_back(mk(CMD_WRITE,  SelCtrlA, 8'h0D, 1'b0, 8'h00, 8'h00)); // input, falling
    opening.push_back(mk(CMD_CA2,    SelDataA, 8'h00, 1'b0, 8'h00, 8'h00)); // falling edge flag
    opening.push_back(mk(CMD_LOAD_A, SelDataA, 8'hA5, 1'b0, 8'h00, 8'h00));
    // port B
    opening.push_back(mk(CMD_WRITE,  SelDataB, 8'hFF, 1'b0, 8'h00, 8'h00)); // direction write
    opening.push_back(mk(CMD_WRITE,  SelCtrlB, 8'h3F, 1'b0, 8'h00, 8'h00)); // manual level high
    opening.push_back(mk(CMD_CB1,    SelDataB, 8'h00, 1'b1, 8'h00, 8'h00)); // rising edge flag
    opening.push_back(mk(CMD_CB2,    SelDataB, 8'h00, 1'b0, 8'h00, 8'h00)); // ignored, output
    opening.push_back(mk(CMD_WRITE,  SelCtrlB, 8'h37, 1'b0, 8'h00, 8'h00)); // strobe mode
    opening.push_back(mk(CMD_WRITE,  SelDataB, 8'h00, 1'b0, 8'h00, 8'h00)); // strobe pulse
    opening.push_back(mk(CMD_LOAD_B, SelDataB, 8'h5A, 1'b0, 8'h00, 8'h00));
    opening.push_back(mk(CMD_WRITE,  SelCtrlB, 8'h1D, 1'b0, 8'h00, 8'h00)); // input, rising
    opening.push_back(mk(CMD_CB2,    SelDataB, 8'h00, 1'b0, 8'h00, 8'h00)); // falling, no flag
    opening.push_back(mk(CMD_CB2,    SelDataB, 8'h00, 1'b1, 8'h00, 8'h00)); // rising edge flag
    opening.push_back(mk(CMD_READ,   SelCtrlB, 8'h00, 1'b0, 8'h00, 8'h00)); // both flags
    opening.push_back(mk(CMD_READ,   SelDataB, 8'h00, 1'b0, 8'h00, 8'hFF)); // merge, clear

    foreach (opening[i])
      send_item(opening[i]);

    // random part; one stretch in the middle runs without sender gaps
    for (int unsigned n = 0; n < RandomItems; n++) begin
      gaps_on = !(n >= 300 && n < 450);
      send_item(random_item());
    end
    s_axis_tvalid <= 1'b0;

    // drain, then keep running on for anything stray
    while (pending != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);

    $display("sent %0d items: %0d reads, %0d writes, %0d line events, %0d loads",
             opening.size() + RandomItems, sent_by_cmd[CMD_READ], sent_by_cmd[CMD_WRITE],
             sent_by_cmd[CMD_CA1] + sent_by_cmd[CMD_CA2] + sent_by_cmd[CMD_CB1]
               + sent_by_cmd[CMD_CB2],
             sent_by_cmd[CMD_LOAD_A] + sent_by_cmd[CMD_LOAD_B]);
    $display("sender gaps and receiver stalls mixed, %0d mismatching fields", mismatches);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
